>>> sv/dhcf_pkg.sv
// Shared constants, codes and types of the detector hit calibration filter.
// Used by every module of the block; depends on nothing.
`default_nettype none

package dhcf_pkg;

    localparam int NUM_TELESCOPES_DEF = 1024;

    // Field widths of the stream items.
    localparam int TEL_W   = 10;
    localparam int RAW_W   = 16;
    localparam int TRIG_W  = 4;
    localparam int PAT_W   = 16;
    localparam int SEL_W   = 2;
    localparam int OFF_W   = 24;
    localparam int SAT_W   = 16;
    localparam int E_W     = 32;
    localparam int IN_DATA_W  = 152;
    localparam int OUT_DATA_W = 96;

    // Arithmetic widths.
    localparam int Q_W        = 32;           // quotient of (raw << 16) / gain
    localparam int DIV_STAGES = Q_W;          // one quotient bit per stage
    localparam int NUM_LANES  = 2;
    localparam int LANE_FAST  = 0;
    localparam int LANE_SLOW  = 1;
    localparam int CF_W       = 40;           // global factor times table factor
    localparam int MC_W       = 39;           // magnitude of that product
    localparam int MC_SPLIT   = 20;           // split point of that magnitude for the partial products
    localparam int PROD_W     = E_W + MC_W;
    localparam int Q_SH       = 16;
    localparam int QC_W       = PROD_W - Q_SH;

    // Configuration port.
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_TRIG_MATCH = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PAT_SEL    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_TEL_MIN    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TEL_MAX    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_GSLOW      = 3'd4;

    localparam logic signed [4:0] TRIG_MATCH_RST = -5'sd1;
    localparam logic [4:0]        PAT_SEL_RST    = 5'd0;
    localparam logic [TEL_W-1:0]  TEL_MIN_RST    = 10'd0;
    localparam logic [TEL_W-1:0]  TEL_MAX_RST    = 10'd1023;
    localparam logic [15:0]       GSLOW_RST      = 16'd256;

    // Item kinds and table selectors.
    localparam logic FUNC_HIT   = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    localparam logic [SEL_W-1:0] SEL_FAST = 2'd0;
    localparam logic [SEL_W-1:0] SEL_SLOW = 2'd1;
    localparam logic [SEL_W-1:0] SEL_CORR = 2'd2;

    localparam logic [TRIG_W-1:0] TRIG_REQUIRED = 4'd1;

    localparam logic [RAW_W-1:0]        DEFAULT_GAIN   = 16'd2048;
    localparam logic signed [OFF_W-1:0] DEFAULT_OFFSET = 24'sd17408;
    localparam logic [SAT_W-1:0]        DEFAULT_SAT    = 16'd3530;

    localparam logic signed [E_W-1:0] E_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [E_W-1:0] E_MIN  = 32'sh8000_0000;
    localparam logic signed [E_W-1:0] E_NONE = -32'sd256;

    typedef struct packed {
        logic signed [4:0] trig_match;
        logic [4:0]        pat_sel;
        logic [TEL_W-1:0]  tel_min;
        logic [TEL_W-1:0]  tel_max;
        logic [15:0]       gslow;
    } t_cfg;

    typedef struct packed {
        logic [RAW_W-1:0]        gain;
        logic signed [OFF_W-1:0] offset;
    } t_cal;

    typedef struct packed {
        logic [SAT_W-1:0]        sat;
        logic signed [OFF_W-1:0] factor;
    } t_corr;

    typedef struct packed {
        logic       we_fast;
        logic       we_slow;
        logic       we_corr;
        t_cal       cal;
        t_corr      corr;
    } t_tbl_wr;

    typedef struct packed {
        logic [TEL_W-1:0] tel;
        logic [RAW_W-1:0] fast_high;
        logic [RAW_W-1:0] fast_low;
        logic [RAW_W-1:0] slow_high;
        logic [RAW_W-1:0] slow_low;
        logic [RAW_W-1:0] hit_time;
    } t_hit;

    // Everything a hit needs besides the two quotients.
    typedef struct packed {
        logic [TEL_W-1:0]        tel;
        logic [RAW_W-1:0]        hit_time;
        logic                    fast_hi_nz;
        logic                    fast_lo_nz;
        logic [RAW_W-1:0]        fast_lo;
        logic                    slow_hi_nz;
        logic                    slow_lo_nz;
        logic [RAW_W-1:0]        slow_lo;
        logic signed [OFF_W-1:0] fast_off;
        logic signed [OFF_W-1:0] slow_off;
        logic [SAT_W-1:0]        sat;
        logic signed [OFF_W-1:0] factor;
    } t_side;

endpackage

`default_nettype wire

>>> sv/dhcf_cfg_regs.sv
// Configuration registers of the calibration filter behind an APB-style port.
// Depends on dhcf_pkg.
`default_nettype none

module dhcf_cfg_regs (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             psel,
    input  wire                             penable,
    input  wire                             pwrite,
    input  wire [dhcf_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire [dhcf_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [dhcf_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output dhcf_pkg::t_cfg                  o_cfg
);
    import dhcf_pkg::*;

    t_cfg                 r_cfg;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr;

    assign idx    = paddr[APB_ADDR_W-1:2];
    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trig_match <= TRIG_MATCH_RST;
            r_cfg.pat_sel    <= PAT_SEL_RST;
            r_cfg.tel_min    <= TEL_MIN_RST;
            r_cfg.tel_max    <= TEL_MAX_RST;
            r_cfg.gslow      <= GSLOW_RST;
        end else if (wr) begin
            case (idx)
                REG_TRIG_MATCH: r_cfg.trig_match <= $signed(pwdata[4:0]);
                REG_PAT_SEL:    r_cfg.pat_sel    <= pwdata[4:0];
                REG_TEL_MIN:    r_cfg.tel_min    <= pwdata[TEL_W-1:0];
                REG_TEL_MAX:    r_cfg.tel_max    <= pwdata[TEL_W-1:0];
                REG_GSLOW:      r_cfg.gslow      <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_TRIG_MATCH: prdata = APB_DATA_W'(r_cfg.trig_match);
            REG_PAT_SEL:    prdata = APB_DATA_W'(r_cfg.pat_sel);
            REG_TEL_MIN:    prdata = APB_DATA_W'(r_cfg.tel_min);
            REG_TEL_MAX:    prdata = APB_DATA_W'(r_cfg.tel_max);
            REG_GSLOW:      prdata = APB_DATA_W'(r_cfg.gslow);
            default:        prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> sv/dhcf_tables.sv
// Per-telescope calibration memories: fast/slow gain-offset pairs and the
// saturation/correction pair, each read through a registered output. Depends on dhcf_pkg.
`default_nettype none

module dhcf_tables #(
    parameter int NUM_TELESCOPES = dhcf_pkg::NUM_TELESCOPES_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rd_en,
    input  wire [$clog2(NUM_TELESCOPES)-1:0] i_addr,
    input  dhcf_pkg::t_tbl_wr                i_wr,
    output dhcf_pkg::t_cal                   o_fast,
    output dhcf_pkg::t_cal                   o_slow,
    output dhcf_pkg::t_corr                  o_corr
);
    import dhcf_pkg::*;

    // Both gain/offset pairs share one word; each half is written on its own.
    t_cal [NUM_LANES-1:0] r_cal_mem [NUM_TELESCOPES];
    t_corr                r_corr_mem [NUM_TELESCOPES];
    t_cal [NUM_LANES-1:0] r_cal_rd;
    t_corr                r_corr_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr.we_fast) begin
            r_cal_mem[i_addr][LANE_FAST] <= i_wr.cal;
        end
        if (i_wr.we_slow) begin
            r_cal_mem[i_addr][LANE_SLOW] <= i_wr.cal;
        end
        if (i_rd_en) begin
            r_cal_rd <= r_cal_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we_corr) begin
            r_corr_mem[i_addr] <= i_wr.corr;
        end
        if (i_rd_en) begin
            r_corr_rd <= r_corr_mem[i_addr];
        end
    end

    assign o_fast = r_cal_rd[LANE_FAST];
    assign o_slow = r_cal_rd[LANE_SLOW];
    assign o_corr = r_corr_rd;

endmodule

`default_nettype wire

>>> sv/dhcf_div.sv
// Pipelined restoring divider for (raw << 16) / gain on the fast and slow lanes,
// one quotient bit per stage, carrying the rest of the hit alongside. Depends on dhcf_pkg.
`default_nettype none

module dhcf_div (
    input  wire                                                 i_clk,
    input  wire                                                 i_rst_n,
    input  wire                                                 i_adv,
    input  wire                                                 i_valid,
    input  wire [dhcf_pkg::NUM_LANES-1:0][dhcf_pkg::RAW_W-1:0]  i_num,
    input  wire [dhcf_pkg::NUM_LANES-1:0][dhcf_pkg::RAW_W-1:0]  i_den,
    input  dhcf_pkg::t_side                                     i_side,
    output logic                                                o_valid,
    output logic [dhcf_pkg::NUM_LANES-1:0][dhcf_pkg::Q_W-1:0]   o_quo,
    output dhcf_pkg::t_side                                     o_side
);
    import dhcf_pkg::*;

    typedef logic [NUM_LANES-1:0][RAW_W-1:0] t_lanes16;
    typedef logic [NUM_LANES-1:0][Q_W-1:0]   t_lanes32;

    logic [DIV_STAGES-1:0] r_valid;
    logic [DIV_STAGES-1:0] n_valid;
    t_lanes16              r_num  [DIV_STAGES];
    t_lanes16              r_den  [DIV_STAGES];
    t_lanes16              r_rem  [DIV_STAGES];
    t_lanes32              r_quo  [DIV_STAGES];
    t_side                 r_side [DIV_STAGES];
    t_lanes16              n_num  [DIV_STAGES];
    t_lanes16              n_den  [DIV_STAGES];
    t_lanes16              n_rem  [DIV_STAGES];
    t_lanes32              n_quo  [DIV_STAGES];
    t_side                 n_side [DIV_STAGES];

    // Each stage only looks at the registers of the stage before it.
    always_comb begin
        t_lanes16         p_num;
        t_lanes16         p_den;
        t_lanes16         p_rem;
        t_lanes32         p_quo;
        logic [RAW_W:0]   t;
        logic [RAW_W:0]   diff;
        logic             ge;
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (k == 0) begin
                n_valid[k] = i_valid;
                n_side[k]  = i_side;
                p_num      = i_num;
                p_den      = i_den;
                p_rem      = '0;
                p_quo      = '0;
            end else begin
                n_valid[k] = r_valid[k-1];
                n_side[k]  = r_side[k-1];
                p_num      = r_num[k-1];
                p_den      = r_den[k-1];
                p_rem      = r_rem[k-1];
                p_quo      = r_quo[k-1];
            end
            n_den[k] = p_den;
            for (int l = 0; l < NUM_LANES; l++) begin
                t    = {p_rem[l], p_num[l][RAW_W-1]};
                diff = t - {1'b0, p_den[l]};
                ge   = (t >= {1'b0, p_den[l]});
                // A zero gain subtracts every time and fills the quotient with ones.
                n_rem[k][l] = ge ? diff[RAW_W-1:0] : t[RAW_W-1:0];
                n_quo[k][l] = {p_quo[l][Q_W-2:0], ge};
                n_num[k][l] = {p_num[l][RAW_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_adv) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_num  <= n_num;
            r_den  <= n_den;
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_side <= n_side;
        end
    end

    assign o_valid = r_valid[DIV_STAGES-1];
    assign o_quo   = r_quo[DIV_STAGES-1];
    assign o_side  = r_side[DIV_STAGES-1];

endmodule

`default_nettype wire

>>> sv/dhcf_post.sv
// Energy assembly, saturation check and slow correction after the divider:
// four register stages, with the final selection left to the output register.
// Depends on dhcf_pkg.
`default_nettype none

module dhcf_post (
    input  wire                                               i_clk,
    input  wire                                               i_rst_n,
    input  wire                                               i_adv,
    input  wire                                               i_valid,
    input  wire [dhcf_pkg::NUM_LANES-1:0][dhcf_pkg::Q_W-1:0]  i_quo,
    input  dhcf_pkg::t_side                                   i_side,
    input  wire [15:0]                                        i_gslow,
    output logic                                              o_pending,
    output logic                                              o_emit,
    output logic [dhcf_pkg::TEL_W-1:0]                        o_tel,
    output logic [dhcf_pkg::E_W-1:0]                          o_fast,
    output logic [dhcf_pkg::E_W-1:0]                          o_slow,
    output logic [dhcf_pkg::RAW_W-1:0]                        o_time
);
    import dhcf_pkg::*;

    function automatic logic signed [E_W-1:0] f_calib(
        input logic [Q_W-1:0]        quo,
        input logic signed [OFF_W-1:0] off,
        input logic                  hi_nz,
        input logic                  lo_nz,
        input logic [RAW_W-1:0]      lo
    );
        logic [Q_W-2:0]        qs;
        logic signed [E_W:0]   sum;
        logic signed [E_W-1:0] res;
        qs  = quo[Q_W-1] ? '1 : quo[Q_W-2:0];
        sum = $signed({2'b00, qs}) + (E_W+1)'(off);
        if (hi_nz) begin
            // The offset is at least -2^23, so only the positive side can overflow.
            res = (!sum[E_W] && sum[E_W-1]) ? E_MAX : sum[E_W-1:0];
        end else if (lo_nz) begin
            res = E_W'({lo, 8'b0});
        end else begin
            res = E_NONE;
        end
        return res;
    endfunction

    // Stage 1: calibrated energies and the combined correction factor.
    logic                    r_p1_valid;
    logic [TEL_W-1:0]        r_p1_tel;
    logic [RAW_W-1:0]        r_p1_time;
    logic signed [E_W-1:0]   r_p1_fast;
    logic signed [E_W-1:0]   r_p1_slow;
    logic [SAT_W-1:0]        r_p1_sat;
    logic signed [CF_W-1:0]  r_p1_cf;
    logic signed [CF_W:0]    cf_full;

    // Stage 2: magnitudes and signs.
    logic                    r_p2_valid;
    logic [TEL_W-1:0]        r_p2_tel;
    logic [RAW_W-1:0]        r_p2_time;
    logic signed [E_W-1:0]   r_p2_fast;
    logic signed [E_W-1:0]   r_p2_slow;
    logic                    r_p2_corr;
    logic                    r_p2_neg;
    logic [E_W-1:0]          r_p2_ms;
    logic [MC_W-1:0]         r_p2_mc;
    logic [CF_W-1:0]         mc_full;

    // Stage 3: two partial products.
    logic                           r_p3_valid;
    logic [TEL_W-1:0]               r_p3_tel;
    logic [RAW_W-1:0]               r_p3_time;
    logic signed [E_W-1:0]          r_p3_fast;
    logic signed [E_W-1:0]          r_p3_slow;
    logic                           r_p3_corr;
    logic                           r_p3_neg;
    logic [E_W+MC_SPLIT-1:0]        r_p3_pp_lo;
    logic [E_W+MC_W-MC_SPLIT-1:0]   r_p3_pp_hi;

    // Stage 4: scaled product.
    logic                    r_p4_valid;
    logic [TEL_W-1:0]        r_p4_tel;
    logic [RAW_W-1:0]        r_p4_time;
    logic signed [E_W-1:0]   r_p4_fast;
    logic signed [E_W-1:0]   r_p4_slow;
    logic                    r_p4_corr;
    logic                    r_p4_neg;
    logic [QC_W-1:0]         r_p4_q;
    logic [PROD_W-1:0]       prod;

    logic                    big_pos;
    logic                    big_neg;
    logic signed [E_W-1:0]   corr_val;
    logic signed [E_W-1:0]   slow_fin;

    assign cf_full = $signed({1'b0, i_gslow}) * i_side.factor;
    assign mc_full = r_p1_cf[CF_W-1] ? (~r_p1_cf + 1'b1) : r_p1_cf;
    assign prod    = {r_p3_pp_hi, {MC_SPLIT{1'b0}}} + PROD_W'(r_p3_pp_lo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_p3_valid <= 1'b0;
            r_p4_valid <= 1'b0;
        end else if (i_adv) begin
            r_p1_valid <= i_valid;
            r_p2_valid <= r_p1_valid;
            r_p3_valid <= r_p2_valid;
            r_p4_valid <= r_p3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_p1_tel  <= i_side.tel;
            r_p1_time <= i_side.hit_time;
            r_p1_fast <= f_calib(i_quo[LANE_FAST], i_side.fast_off, i_side.fast_hi_nz,
                                 i_side.fast_lo_nz, i_side.fast_lo);
            r_p1_slow <= f_calib(i_quo[LANE_SLOW], i_side.slow_off, i_side.slow_hi_nz,
                                 i_side.slow_lo_nz, i_side.slow_lo);
            r_p1_sat  <= i_side.sat;
            r_p1_cf   <= cf_full[CF_W-1:0];

            r_p2_tel  <= r_p1_tel;
            r_p2_time <= r_p1_time;
            r_p2_fast <= r_p1_fast;
            r_p2_slow <= r_p1_slow;
            r_p2_corr <= (r_p1_slow < $signed({8'b0, r_p1_sat, 8'b0}));
            r_p2_neg  <= r_p1_slow[E_W-1] ^ r_p1_cf[CF_W-1];
            r_p2_ms   <= r_p1_slow[E_W-1] ? (~r_p1_slow + 1'b1) : r_p1_slow;
            r_p2_mc   <= mc_full[MC_W-1:0];

            r_p3_tel   <= r_p2_tel;
            r_p3_time  <= r_p2_time;
            r_p3_fast  <= r_p2_fast;
            r_p3_slow  <= r_p2_slow;
            r_p3_corr  <= r_p2_corr;
            r_p3_neg   <= r_p2_neg;
            r_p3_pp_lo <= r_p2_ms * r_p2_mc[MC_SPLIT-1:0];
            r_p3_pp_hi <= r_p2_ms * r_p2_mc[MC_W-1:MC_SPLIT];

            r_p4_tel  <= r_p3_tel;
            r_p4_time <= r_p3_time;
            r_p4_fast <= r_p3_fast;
            r_p4_slow <= r_p3_slow;
            r_p4_corr <= r_p3_corr;
            r_p4_neg  <= r_p3_neg;
            r_p4_q    <= prod[PROD_W-1:Q_SH];
        end
    end

    // The corrected magnitude saturates at 2^31 on the negative side, 2^31-1 otherwise.
    assign big_pos = |r_p4_q[QC_W-1:E_W-1];
    assign big_neg = (|r_p4_q[QC_W-1:E_W]) || (r_p4_q[E_W-1] && (|r_p4_q[E_W-2:0]));

    always_comb begin
        if (r_p4_neg) begin
            corr_val = big_neg ? E_MIN : $signed(~r_p4_q[E_W-1:0] + 1'b1);
        end else begin
            corr_val = big_pos ? E_MAX : $signed(r_p4_q[E_W-1:0]);
        end
        slow_fin = r_p4_corr ? corr_val : r_p4_slow;
    end

    assign o_pending = r_p4_valid;
    assign o_emit    = r_p4_valid && (slow_fin > 0) && (r_p4_fast > 0);
    assign o_tel     = r_p4_tel;
    assign o_fast    = r_p4_fast;
    assign o_slow    = slow_fin;
    assign o_time    = r_p4_time;

endmodule

`default_nettype wire

>>> sv/detector_hit_calibration_filter.sv
// Top level of the detector hit calibration filter: hit gating, table writes,
// calibration memories, divider, correction stages and the output register.
// Depends on dhcf_pkg, dhcf_cfg_regs, dhcf_tables, dhcf_div and dhcf_post.
//
//   Channel   Direction  Handshake                 Payload
//   s_axis    in         tvalid / tready           tdata 152 bits, tuser = func
//   m_axis    out        tvalid / tready           tdata 96 bits
//   apb       in         psel, penable, pready     paddr 5, pwdata / prdata 32
//
// One item per clock is accepted while s_axis_tready is high. On its way to m_axis a
// hit passes the memory read at the accepting edge, 32 divider stages (one quotient
// bit each), four correction stages and the output register. Reset clears control
// state only; the tables hold nothing until written and need no clearing pass.
// s_axis_tready falls only while a result waits in the output register and the
// last correction stage also holds an item.
`default_nettype none

module detector_hit_calibration_filter #(
    parameter int NUM_TELESCOPES = dhcf_pkg::NUM_TELESCOPES_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             s_axis_tvalid,
    output logic                            s_axis_tready,
    // telescope[9:0], fast_high[25:10], fast_low[41:26], slow_high[57:42],
    // slow_low[73:58], hit_time[89:74], event_trigger[93:90],
    // event_pattern[109:94], table_select[111:110], word_a[127:112], word_b[151:128]
    input  wire [dhcf_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // func[0]
    input  wire                             s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    // out_telescope[9:0], fast_energy[41:10], slow_energy[73:42], out_time[89:74],
    // zero[95:90]
    output logic [dhcf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  wire                             psel,
    input  wire                             penable,
    input  wire                             pwrite,
    input  wire [dhcf_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire [dhcf_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [dhcf_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import dhcf_pkg::*;

    localparam int AW = $clog2(NUM_TELESCOPES);

    t_cfg                     cfg;
    logic                     adv;
    logic                     accept;

    // Input fields.
    logic [TEL_W-1:0]         in_tel;
    logic [TRIG_W-1:0]        in_trig;
    logic [PAT_W-1:0]         in_pat;
    logic [SEL_W-1:0]         in_sel;
    logic [RAW_W-1:0]         in_wa;
    logic signed [OFF_W-1:0]  in_wb;
    t_hit                     in_hit;

    logic                     tel_ok;
    logic                     trig_ok;
    logic                     pat_ok;
    logic                     range_ok;
    logic [4:0]               pat_idx;
    logic                     zero_pair;
    t_tbl_wr                  tbl_wr;

    logic                     r_a_valid;
    t_hit                     r_a_hit;
    t_cal                     rd_fast;
    t_cal                     rd_slow;
    t_corr                    rd_corr;

    t_side                    div_side_in;
    logic [NUM_LANES-1:0][RAW_W-1:0] div_num;
    logic [NUM_LANES-1:0][RAW_W-1:0] div_den;
    logic                     div_valid;
    logic [NUM_LANES-1:0][Q_W-1:0]   div_quo;
    t_side                    div_side;

    logic                     post_pending;
    logic                     post_emit;
    logic [TEL_W-1:0]         post_tel;
    logic [E_W-1:0]           post_fast;
    logic [E_W-1:0]           post_slow;
    logic [RAW_W-1:0]         post_time;

    logic                     r_m_valid;
    logic [TEL_W-1:0]         r_m_tel;
    logic [E_W-1:0]           r_m_fast;
    logic [E_W-1:0]           r_m_slow;
    logic [RAW_W-1:0]         r_m_time;

    dhcf_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // The pipeline moves as one; it holds while a waiting result blocks a pending item.
    assign adv           = !r_m_valid || m_axis_tready || !post_pending;
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign in_tel           = s_axis_tdata[9:0];
    assign in_hit.tel       = in_tel;
    assign in_hit.fast_high = s_axis_tdata[25:10];
    assign in_hit.fast_low  = s_axis_tdata[41:26];
    assign in_hit.slow_high = s_axis_tdata[57:42];
    assign in_hit.slow_low  = s_axis_tdata[73:58];
    assign in_hit.hit_time  = s_axis_tdata[89:74];
    assign in_trig          = s_axis_tdata[93:90];
    assign in_pat           = s_axis_tdata[109:94];
    assign in_sel           = s_axis_tdata[111:110];
    assign in_wa            = s_axis_tdata[127:112];
    assign in_wb            = $signed(s_axis_tdata[151:128]);

    assign tel_ok   = int'(in_tel) < NUM_TELESCOPES;
    // A negative trigger match disables the comparison; trigger one is always required.
    assign trig_ok  = (cfg.trig_match[4] || ({1'b0, in_trig} == cfg.trig_match))
                      && (in_trig == TRIG_REQUIRED);
    assign pat_idx  = cfg.pat_sel - 5'd1;
    assign pat_ok   = (cfg.pat_sel == '0)
                      || ((cfg.pat_sel <= 5'(PAT_W)) && in_pat[pat_idx[3:0]]);
    assign range_ok = (in_tel >= cfg.tel_min) && (in_tel <= cfg.tel_max);

    // An all-zero gain/offset pair loads the default calibration.
    assign zero_pair = (in_wa == '0) && (in_wb == '0);

    always_comb begin
        tbl_wr.we_fast     = accept && (s_axis_tuser == FUNC_WRITE) && tel_ok
                             && (in_sel == SEL_FAST);
        tbl_wr.we_slow     = accept && (s_axis_tuser == FUNC_WRITE) && tel_ok
                             && (in_sel == SEL_SLOW);
        tbl_wr.we_corr     = accept && (s_axis_tuser == FUNC_WRITE) && tel_ok
                             && (in_sel == SEL_CORR);
        tbl_wr.cal.gain    = zero_pair ? DEFAULT_GAIN : in_wa;
        tbl_wr.cal.offset  = zero_pair ? DEFAULT_OFFSET : in_wb;
        tbl_wr.corr.sat    = (in_wa == '0) ? DEFAULT_SAT : in_wa;
        tbl_wr.corr.factor = in_wb;
    end

    dhcf_tables #(
        .NUM_TELESCOPES (NUM_TELESCOPES)
    ) u_tables (
        .i_clk   (i_clk),
        .i_rd_en (adv),
        .i_addr  (AW'(in_tel)),
        .i_wr    (tbl_wr),
        .o_fast  (rd_fast),
        .o_slow  (rd_slow),
        .o_corr  (rd_corr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= accept && (s_axis_tuser == FUNC_HIT) && tel_ok && trig_ok
                         && pat_ok && range_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_hit <= in_hit;
        end
    end

    always_comb begin
        div_num[LANE_FAST]     = r_a_hit.fast_high;
        div_num[LANE_SLOW]     = r_a_hit.slow_high;
        div_den[LANE_FAST]     = rd_fast.gain;
        div_den[LANE_SLOW]     = rd_slow.gain;
        div_side_in.tel        = r_a_hit.tel;
        div_side_in.hit_time   = r_a_hit.hit_time;
        div_side_in.fast_hi_nz = (r_a_hit.fast_high != '0);
        div_side_in.fast_lo_nz = (r_a_hit.fast_low != '0);
        div_side_in.fast_lo    = r_a_hit.fast_low;
        div_side_in.slow_hi_nz = (r_a_hit.slow_high != '0);
        div_side_in.slow_lo_nz = (r_a_hit.slow_low != '0);
        div_side_in.slow_lo    = r_a_hit.slow_low;
        div_side_in.fast_off   = rd_fast.offset;
        div_side_in.slow_off   = rd_slow.offset;
        div_side_in.sat        = rd_corr.sat;
        div_side_in.factor     = rd_corr.factor;
    end

    dhcf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r_a_valid),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_side  (div_side_in),
        .o_valid (div_valid),
        .o_quo   (div_quo),
        .o_side  (div_side)
    );

    dhcf_post u_post (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_valid   (div_valid),
        .i_quo     (div_quo),
        .i_side    (div_side),
        .i_gslow   (cfg.gslow),
        .o_pending (post_pending),
        .o_emit    (post_emit),
        .o_tel     (post_tel),
        .o_fast    (post_fast),
        .o_slow    (post_slow),
        .o_time    (post_time)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (adv && post_emit) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && post_emit) begin
            r_m_tel  <= post_tel;
            r_m_fast <= post_fast;
            r_m_slow <= post_slow;
            r_m_time <= post_time;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W - TEL_W - 2*E_W - RAW_W){1'b0}},
                            r_m_time, r_m_slow, r_m_fast, r_m_tel};

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking testbench for the detector hit calibration filter.
// Drives calibration-table writes and hits, predicts every result and checks it.
// Depends on dhcf_pkg and detector_hit_calibration_filter.
`timescale 1ns / 1ps

module tb_top;
    import dhcf_pkg::*;

    localparam int NUM_TEL      = NUM_TELESCOPES_DEF;
    localparam int PIPE_LATENCY = 37;
    localparam int IDLE_PCT     = 33;

    localparam logic [SEL_W-1:0]     SEL_NONE     = 2'd3;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    // Field order follows the tdata layout, highest bits first.
    typedef struct packed {
        logic signed [OFF_W-1:0] word_b;
        logic [RAW_W-1:0]        word_a;
        logic [SEL_W-1:0]        table_sel;
        logic [PAT_W-1:0]        pattern;
        logic [TRIG_W-1:0]       trigger;
        logic [RAW_W-1:0]        hit_time;
        logic [RAW_W-1:0]        slow_low;
        logic [RAW_W-1:0]        slow_high;
        logic [RAW_W-1:0]        fast_low;
        logic [RAW_W-1:0]        fast_high;
        logic [TEL_W-1:0]        tel;
    } t_item_data;

    typedef struct packed {
        logic       func;
        t_item_data data;
    } t_stream_item;

    typedef struct packed {
        logic [5:0]              pad;
        logic [RAW_W-1:0]        out_time;
        logic signed [E_W-1:0]   slow;
        logic signed [E_W-1:0]   fast;
        logic [TEL_W-1:0]        tel;
    } t_cal_result;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    wire                     s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata = '0;
    logic                    s_axis_tuser = 1'b0;
    wire                     m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    wire  [OUT_DATA_W-1:0]   m_axis_tdata;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr = '0;
    logic [APB_DATA_W-1:0]   pwdata = '0;
    wire  [APB_DATA_W-1:0]   prdata;
    wire                     pready;

    // Shadow copy of the block's tables and registers.
    t_cal  fast_cal [NUM_TEL];
    t_cal  slow_cal [NUM_TEL];
    t_corr corr_tab [NUM_TEL];
    t_cfg  cfg_now = '{TRIG_MATCH_RST, PAT_SEL_RST, TEL_MIN_RST, TEL_MAX_RST, GSLOW_RST};

    // Which tables each telescope has had written; hits only go to complete ones.
    bit fast_set [NUM_TEL];
    bit slow_set [NUM_TEL];
    bit corr_set [NUM_TEL];
    bit is_ready [NUM_TEL];
    int ready_tels[$];

    t_stream_item pending_items[$];
    t_cal_result  calibrated_hits[$];
    t_stream_item next_item;
    t_cal_result  got_hit;
    t_cal_result  want_hit;
    int           stall_pct = IDLE_PCT;
    int           mismatch_count = 0;

    detector_hit_calibration_filter u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic signed [E_W-1:0] sat32(input longint v);
        if (v > 64'sh7FFF_FFFF) begin
            return E_MAX;
        end
        if (v < -64'sh8000_0000) begin
            return E_MIN;
        end
        return v[E_W-1:0];
    endfunction

    // High-gain channel divided by the gain plus offset, else low gain, else -1.0.
    function automatic logic signed [E_W-1:0] chan_energy(
        input logic [RAW_W-1:0] hi, input logic [RAW_W-1:0] lo,
        input logic [RAW_W-1:0] gain, input logic signed [OFF_W-1:0] offset);
        longint unsigned q;
        if (hi != 0) begin
            if (gain == 0) begin
                q = 64'h7FFF_FFFF;
            end else begin
                q = {32'd0, hi, 16'd0} / gain;
                if (q > 64'h7FFF_FFFF) begin
                    q = 64'h7FFF_FFFF;
                end
            end
            return sat32(longint'(q) + longint'(offset));
        end
        if (lo != 0) begin
            return {8'd0, lo, 8'd0};
        end
        return E_NONE;
    endfunction

    // Slow times the Q8.8 and Q16.8 factors, truncated toward zero and saturated.
    function automatic logic signed [E_W-1:0] scale_slow(
        input logic signed [E_W-1:0] slow, input logic signed [OFF_W-1:0] factor,
        input logic [15:0] gs);
        longint     cf;
        logic       neg;
        logic [127:0] ms, mc, q;
        cf  = longint'({1'b0, gs}) * longint'(factor);
        neg = (slow < 0) != (cf < 0);
        ms  = 128'((slow < 0) ? -longint'(slow) : longint'(slow));
        mc  = 128'((cf < 0) ? -cf : cf);
        if (ms == 0 || mc == 0) begin
            return '0;
        end
        q = (ms * mc) >> 16;
        if (neg) begin
            if (q > (128'd1 << 31)) begin
                return E_MIN;
            end
            return -$signed(q[31:0]);
        end
        if (q > 128'h7FFF_FFFF) begin
            return E_MAX;
        end
        return q[31:0];
    endfunction

    task automatic calibrate_item(input logic func, input t_item_data d);
        t_cal                  cal;
        logic signed [E_W-1:0] fast_e, slow_e;
        logic [4:0]            bit_idx;
        logic                  pass;
        t_cal_result           r;
        if (func == FUNC_WRITE) begin
            cal.gain   = d.word_a;
            cal.offset = d.word_b;
            if (d.word_a == 0 && d.word_b == 0) begin
                cal.gain   = DEFAULT_GAIN;
                cal.offset = DEFAULT_OFFSET;
            end
            case (d.table_sel)
                SEL_FAST: fast_cal[d.tel] = cal;
                SEL_SLOW: slow_cal[d.tel] = cal;
                SEL_CORR: begin
                    corr_tab[d.tel].sat    = (d.word_a == 0) ? DEFAULT_SAT : d.word_a;
                    corr_tab[d.tel].factor = d.word_b;
                end
                default: ;
            endcase
        end else begin
            pass = 1'b1;
            if ($signed(cfg_now.trig_match) >= 0 &&
                    $signed({1'b0, d.trigger}) != $signed(cfg_now.trig_match)) begin
                pass = 1'b0;
            end
            if (cfg_now.pat_sel != 0) begin
                bit_idx = cfg_now.pat_sel - 5'd1;
                if (bit_idx >= 16 || !d.pattern[bit_idx[3:0]]) begin
                    pass = 1'b0;
                end
            end
            if (d.trigger != TRIG_REQUIRED) begin
                pass = 1'b0;
            end
            if (pass) begin
                fast_e = chan_energy(d.fast_high, d.fast_low,
                                     fast_cal[d.tel].gain, fast_cal[d.tel].offset);
                slow_e = chan_energy(d.slow_high, d.slow_low,
                                     slow_cal[d.tel].gain, slow_cal[d.tel].offset);
                if (longint'(slow_e) < longint'({corr_tab[d.tel].sat, 8'd0})) begin
                    slow_e = scale_slow(slow_e, corr_tab[d.tel].factor, cfg_now.gslow);
                end
                if (slow_e > 0 && fast_e > 0 &&
                        d.tel >= cfg_now.tel_min && d.tel <= cfg_now.tel_max) begin
                    r          = '0;
                    r.tel      = d.tel;
                    r.fast     = fast_e;
                    r.slow     = slow_e;
                    r.out_time = d.hit_time;
                    calibrated_hits.push_back(r);
                end
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                   input logic [31:0] want_v);
        mismatch_count++;
        $display("ERROR at %0t: %s: got 0x%08h, expected 0x%08h",
                 $realtime, what, got_v, want_v);
    endtask

    // Input side: items leave the pending queue with random gaps.
    always @(posedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || s_axis_tready)) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= stall_pct) begin
                next_item = pending_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= next_item.func;
                s_axis_tdata  <= next_item.data;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            calibrate_item(s_axis_tuser, t_item_data'(s_axis_tdata));
        end
    end

    // Output side: random back-pressure and a field-by-field check.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_hit = m_axis_tdata;
            if (calibrated_hits.size() == 0) begin
                report_mismatch("result with no hit expected", 32'(got_hit.tel), 32'd0);
            end else begin
                want_hit = calibrated_hits.pop_front();
                if (got_hit.tel != want_hit.tel) begin
                    report_mismatch("out_telescope", 32'(got_hit.tel), 32'(want_hit.tel));
                end
                if (got_hit.fast != want_hit.fast) begin
                    report_mismatch("fast_energy", got_hit.fast, want_hit.fast);
                end
                if (got_hit.slow != want_hit.slow) begin
                    report_mismatch("slow_energy", got_hit.slow, want_hit.slow);
                end
                if (got_hit.out_time != want_hit.out_time) begin
                    report_mismatch("out_time", 32'(got_hit.out_time),
                                    32'(want_hit.out_time));
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_TRIG_MATCH: cfg_now.trig_match = value[4:0];
            REG_PAT_SEL:    cfg_now.pat_sel    = value[4:0];
            REG_TEL_MIN:    cfg_now.tel_min    = value[TEL_W-1:0];
            REG_TEL_MAX:    cfg_now.tel_max    = value[TEL_W-1:0];
            REG_GSLOW:      cfg_now.gslow      = value[15:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input logic signed [4:0] trig, input logic [4:0] pat_bit,
                              input logic [TEL_W-1:0] tmin, input logic [TEL_W-1:0] tmax,
                              input logic [15:0] gs);
        write_reg(REG_TRIG_MATCH, {27'd0, trig});
        write_reg(REG_PAT_SEL, {27'd0, pat_bit});
        write_reg(REG_TEL_MIN, {22'd0, tmin});
        write_reg(REG_TEL_MAX, {22'd0, tmax});
        write_reg(REG_GSLOW, {16'd0, gs});
    endtask

    // Drained means nothing queued, nothing offered and nothing outstanding.
    // Writes and dropped hits leave no trace, so the pipeline gets time to empty.
    task automatic wait_idle();
        while (pending_items.size() != 0 || s_axis_tvalid || calibrated_hits.size() != 0)
            @(negedge i_clk);
        repeat (PIPE_LATENCY + 10) @(posedge i_clk);
    endtask

    function automatic t_item_data random_data();
        logic [159:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        return raw[IN_DATA_W-1:0];
    endfunction

    task automatic push_write(input logic [TEL_W-1:0] tel, input logic [SEL_W-1:0] sel,
                              input logic [RAW_W-1:0] wa, input logic signed [OFF_W-1:0] wb);
        t_stream_item it;
        it.func           = FUNC_WRITE;
        it.data           = random_data();
        it.data.tel       = tel;
        it.data.table_sel = sel;
        it.data.word_a    = wa;
        it.data.word_b    = wb;
        pending_items.push_back(it);
        case (sel)
            SEL_FAST: fast_set[tel] = 1'b1;
            SEL_SLOW: slow_set[tel] = 1'b1;
            SEL_CORR: corr_set[tel] = 1'b1;
            default: ;
        endcase
        if (fast_set[tel] && slow_set[tel] && corr_set[tel] && !is_ready[tel]) begin
            is_ready[tel] = 1'b1;
            ready_tels.push_back(int'(tel));
        end
    endtask

    task automatic push_hit(input logic [TEL_W-1:0] tel,
                            input logic [RAW_W-1:0] fh, input logic [RAW_W-1:0] fl,
                            input logic [RAW_W-1:0] sh, input logic [RAW_W-1:0] sl,
                            input logic [TRIG_W-1:0] trig, input logic [PAT_W-1:0] pat,
                            input logic [RAW_W-1:0] tm);
        t_stream_item it;
        it.func           = FUNC_HIT;
        it.data           = random_data();
        it.data.tel       = tel;
        it.data.fast_high = fh;
        it.data.fast_low  = fl;
        it.data.slow_high = sh;
        it.data.slow_low  = sl;
        it.data.trigger   = trig;
        it.data.pattern   = pat;
        it.data.hit_time  = tm;
        pending_items.push_back(it);
    endtask

    function automatic logic [RAW_W-1:0] rand_gain();
        case ($urandom_range(9))
            0:       return '0;
            1:       return 16'hFFFF;
            2, 3:    return RAW_W'($urandom_range(1, 255));
            default: return RAW_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [OFF_W-1:0] rand_offset();
        case ($urandom_range(9))
            0, 1:    return '0;
            2:       return 24'sh7F_FFFF;
            3:       return 24'sh80_0000;
            4, 5:    return OFF_W'($urandom);
            default: return OFF_W'($urandom_range(36864) - 4096);
        endcase
    endfunction

    function automatic logic [SAT_W-1:0] rand_sat();
        case ($urandom_range(7))
            0:       return '0;
            1:       return 16'hFFFF;
            default: return SAT_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [OFF_W-1:0] rand_factor();
        case ($urandom_range(9))
            6:       return '0;
            7:       return -$signed({1'b0, 23'($urandom_range(1, 512))});
            8:       return OFF_W'($urandom);
            9:       return $urandom_range(1) ? 24'sh7F_FFFF : 24'sh80_0000;
            default: return OFF_W'($urandom_range(64, 1024));
        endcase
    endfunction

    function automatic logic [RAW_W-1:0] rand_chan();
        case ($urandom_range(9))
            0, 1:    return '0;
            2:       return 16'hFFFF;
            default: return RAW_W'($urandom);
        endcase
    endfunction

    // Mostly hits on fully calibrated telescopes; the rest sets up new
    // telescopes or rewrites single tables, the unused selector included.
    task automatic random_items(input int n);
        int                  done;
        int                  k;
        logic [TEL_W-1:0]    tel;
        logic [SEL_W-1:0]    sel;
        logic [TRIG_W-1:0]   trig;
        logic [PAT_W-1:0]    pat;
        done = 0;
        while (done < n) begin
            k = $urandom_range(99);
            if (k < 6) begin
                tel = TEL_W'($urandom_range(NUM_TEL - 1));
                push_write(tel, SEL_FAST, rand_gain(), rand_offset());
                push_write(tel, SEL_SLOW, rand_gain(), rand_offset());
                push_write(tel, SEL_CORR, rand_sat(), rand_factor());
                done += 3;
            end else if (k < 20) begin
                if ($urandom_range(1))
                    tel = TEL_W'(ready_tels[$urandom_range(ready_tels.size() - 1)]);
                else
                    tel = TEL_W'($urandom_range(NUM_TEL - 1));
                sel = SEL_W'($urandom_range(3));
                if (sel == SEL_CORR)
                    push_write(tel, sel, rand_sat(), rand_factor());
                else if (sel == SEL_NONE)
                    push_write(tel, sel, RAW_W'($urandom), OFF_W'($urandom));
                else
                    push_write(tel, sel, rand_gain(), rand_offset());
                done++;
            end else begin
                tel  = TEL_W'(ready_tels[$urandom_range(ready_tels.size() - 1)]);
                trig = ($urandom_range(9) < 8) ? TRIG_REQUIRED : 4'($urandom_range(15));
                pat  = PAT_W'($urandom);
                if (cfg_now.pat_sel != 0 && cfg_now.pat_sel <= 16 && $urandom_range(9) < 8)
                    pat[cfg_now.pat_sel - 5'd1] = 1'b1;
                push_hit(tel, rand_chan(), rand_chan(), rand_chan(), rand_chan(),
                         trig, pat, RAW_W'($urandom));
                done++;
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items at the reset configuration.
        push_write(10'd0, SEL_FAST, 16'd0, 24'sd0);      // zero pair takes the defaults
        push_write(10'd0, SEL_SLOW, 16'd0, 24'sd0);
        push_write(10'd0, SEL_CORR, 16'd0, 24'sd256);    // zero saturation takes the default
        push_write(10'd1023, SEL_FAST, 16'hFFFF, 24'sh7F_FFFF);
        push_write(10'd1023, SEL_SLOW, 16'd1, 24'sh80_0000);
        push_write(10'd1023, SEL_CORR, 16'hFFFF, 24'sh80_0000);
        push_write(10'd5, SEL_FAST, 16'd0, 24'sd100);    // zero gain, division saturates
        push_write(10'd5, SEL_SLOW, 16'd256, 24'sd0);
        push_write(10'd5, SEL_CORR, 16'd1, 24'sh7F_FFFF);
        push_write(10'd5, SEL_NONE, 16'd0, 24'sd0);      // ignored selector
        push_hit(10'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, TRIG_REQUIRED, 16'hFFFF,
                 16'hFFFF);
        push_hit(10'd0, 16'd0, 16'd1, 16'd0, 16'hFFFF, TRIG_REQUIRED, 16'd0, 16'd0);
        push_hit(10'd0, 16'd0, 16'd0, 16'd0, 16'd0, TRIG_REQUIRED, 16'd0, 16'd7);
        push_hit(10'd0, 16'd100, 16'd0, 16'd100, 16'd0, TRIG_REQUIRED, 16'h5555, 16'd99);
        push_hit(10'd1023, 16'hFFFF, 16'd0, 16'd1, 16'd0, TRIG_REQUIRED, 16'h8000, 16'd1234);
        push_hit(10'd1023, 16'd1, 16'd1, 16'hFFFF, 16'd0, TRIG_REQUIRED, 16'h0001, 16'hAAAA);
        push_hit(10'd5, 16'd300, 16'd0, 16'd300, 16'd0, TRIG_REQUIRED, 16'd0, 16'd5);
        push_hit(10'd5, 16'd10, 16'd0, 16'd0, 16'd2, TRIG_REQUIRED, 16'd0, 16'd6);
        push_hit(10'd0, 16'd100, 16'd0, 16'd100, 16'd0, 4'd0, 16'd0, 16'd8);
        push_hit(10'd0, 16'd100, 16'd0, 16'd100, 16'd0, 4'hF, 16'd0, 16'd9);

        wait_idle();
        set_config(5'sd1, 5'd16, 10'd0, 10'd1023, 16'd256);
        random_items(300);
        wait_idle();
        set_config(-5'sd1, 5'd1, 10'd0, 10'd1023, 16'd0);
        random_items(200);
        wait_idle();
        set_config(5'sd15, 5'd0, 10'd0, 10'd1023, 16'd256);
        random_items(60);
        wait_idle();
        set_config(-5'sd1, 5'd20, 10'd0, 10'd1023, 16'd256);   // pattern bit past the top
        random_items(60);
        wait_idle();
        set_config(-5'sd1, 5'd0, 10'd100, 10'd900, 16'hFFFF);
        stall_pct = 0;
        random_items(400);
        wait_idle();
        stall_pct = IDLE_PCT;
        set_config(5'sd0, 5'd0, 10'd0, 10'd1023, 16'd256);
        random_items(40);
        wait_idle();
        set_config(-5'sd1, 5'd8, 10'd1023, 10'd0, 16'd512);   // empty telescope window
        random_items(80);
        wait_idle();
        set_config(-5'sd1, 5'd0, 10'd512, 10'd1023, 16'd384);
        write_reg(REG_SPARE_LO, $urandom);
        write_reg(REG_SPARE_HI, $urandom);
        random_items(160);
        wait_idle();
        set_config(-5'sd1, 5'd0, 10'd0, 10'd1023, 16'd1);
        random_items(400);
        wait_idle();

        if (mismatch_count == 0 && calibrated_hits.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

>>> detector_hit_calibration_filter.f
sv/dhcf_pkg.sv
sv/dhcf_cfg_regs.sv
sv/dhcf_tables.sv
sv/dhcf_div.sv
sv/dhcf_post.sv
sv/detector_hit_calibration_filter.sv
tb/sv/tb_top.sv
